/* src/cau_pkg.sv */
// Shared types, codes and a helper function for the complex arithmetic unit.
package cau_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int QUOT_W    = 32;
   localparam int REM_W     = PROD_W + FRAC_BITS + QUOT_W;
   localparam int STEP_W    = $clog2(QUOT_W);

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_DIVZERO = 2'd1;
   localparam logic [1:0] ST_SAT     = 2'd2;

   typedef struct packed {
      logic [1:0]        op;
      logic [DATA_W-1:0] a_re;
      logic [DATA_W-1:0] a_im;
      logic [DATA_W-1:0] b_re;
      logic [DATA_W-1:0] b_im;
   } operand_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [PROD_W-1:0] p_rr;
      logic [PROD_W-1:0] p_ii;
      logic [PROD_W-1:0] p_ir;
      logic [PROD_W-1:0] p_ri;
      logic [PROD_W-1:0] p_br2;
      logic [PROD_W-1:0] p_bi2;
      logic [DATA_W:0]   s_re;
      logic [DATA_W:0]   s_im;
   } prod_type;

   typedef struct packed {
      logic [1:0]        op;
      logic              neg_re;
      logic              neg_im;
      logic [PROD_W-1:0] mag_re;
      logic [PROD_W-1:0] mag_im;
      logic [PROD_W-1:0] den;
   } mag_type;

   typedef struct packed {
      logic [1:0]        op;
      logic              dz;
      logic              neg_re;
      logic              neg_im;
      logic              big_re;
      logic              big_im;
      logic [REM_W-1:0]  rem_re;
      logic [REM_W-1:0]  rem_im;
      logic [PROD_W-1:0] den;
      logic [QUOT_W-1:0] q_re;
      logic [QUOT_W-1:0] q_im;
      logic [DATA_W-1:0] res_re;
      logic [DATA_W-1:0] res_im;
      logic              sat;
   } div_type;

   typedef struct packed {
      logic [DATA_W-1:0] res_re;
      logic [DATA_W-1:0] res_im;
      logic [1:0]        status;
   } result_type;

   typedef struct packed {
      logic              sat;
      logic [DATA_W-1:0] value;
   } clamp_type;

   localparam logic [SUM_W-1:0] POS_MAX = SUM_W'({1'b0, {(DATA_W-1){1'b1}}});
   localparam logic [SUM_W-1:0] NEG_MAX = SUM_W'({1'b1, {(DATA_W-1){1'b0}}});
   localparam logic [SUM_W-1:0] BIG_MAG = SUM_W'({2'b01, {(DATA_W-1){1'b0}}, 1'b1});

   function automatic clamp_type clamp32(input logic neg, input logic [SUM_W-1:0] mag);
      clamp_type c;
      c.sat = 1'b0;
      if (neg) begin
         if (mag > NEG_MAX) begin
            c.sat   = 1'b1;
            c.value = NEG_MAX[DATA_W-1:0];
         end else begin
            c.value = DATA_W'(-mag[DATA_W-1:0]);
         end
      end else begin
         if (mag > POS_MAX) begin
            c.sat   = 1'b1;
            c.value = POS_MAX[DATA_W-1:0];
         end else begin
            c.value = mag[DATA_W-1:0];
         end
      end
      return c;
   endfunction

endpackage

/* src/cau_front.sv */
// Input, multiplier and sign-magnitude stages of the complex arithmetic unit.
module cau_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  cau_pkg::operand_type  in_data,
   output logic                  out_valid,
   output cau_pkg::mag_type      out_data
);

   logic                 s0_valid_ff, s1_valid_ff, s2_valid_ff;
   cau_pkg::operand_type s0_ff;
   cau_pkg::prod_type    s1_ff, s1_in;
   cau_pkg::mag_type     s2_ff, s2_in;
   logic signed [cau_pkg::SUM_W-1:0] sum_re, sum_im, neg_re, neg_im;

   always_comb begin
      s1_in.op    = s0_ff.op;
      s1_in.p_rr  = $signed(s0_ff.a_re) * $signed(s0_ff.b_re);
      s1_in.p_ii  = $signed(s0_ff.a_im) * $signed(s0_ff.b_im);
      s1_in.p_ir  = $signed(s0_ff.a_im) * $signed(s0_ff.b_re);
      s1_in.p_ri  = $signed(s0_ff.a_re) * $signed(s0_ff.b_im);
      s1_in.p_br2 = $signed(s0_ff.b_re) * $signed(s0_ff.b_re);
      s1_in.p_bi2 = $signed(s0_ff.b_im) * $signed(s0_ff.b_im);
      if (s0_ff.op == cau_pkg::OP_ADD) begin
         s1_in.s_re = $signed({s0_ff.a_re[31], s0_ff.a_re}) + $signed({s0_ff.b_re[31], s0_ff.b_re});
         s1_in.s_im = $signed({s0_ff.a_im[31], s0_ff.a_im}) + $signed({s0_ff.b_im[31], s0_ff.b_im});
      end else begin
         s1_in.s_re = $signed({s0_ff.a_re[31], s0_ff.a_re}) - $signed({s0_ff.b_re[31], s0_ff.b_re});
         s1_in.s_im = $signed({s0_ff.a_im[31], s0_ff.a_im}) - $signed({s0_ff.b_im[31], s0_ff.b_im});
      end
   end

   always_comb begin
      case (s1_ff.op)
         cau_pkg::OP_MUL: begin
            sum_re = $signed({s1_ff.p_rr[63], s1_ff.p_rr}) - $signed({s1_ff.p_ii[63], s1_ff.p_ii});
            sum_im = $signed({s1_ff.p_ir[63], s1_ff.p_ir}) + $signed({s1_ff.p_ri[63], s1_ff.p_ri});
         end
         cau_pkg::OP_DIV: begin
            sum_re = $signed({s1_ff.p_rr[63], s1_ff.p_rr}) + $signed({s1_ff.p_ii[63], s1_ff.p_ii});
            sum_im = $signed({s1_ff.p_ir[63], s1_ff.p_ir}) - $signed({s1_ff.p_ri[63], s1_ff.p_ri});
         end
         default: begin
            sum_re = cau_pkg::SUM_W'($signed(s1_ff.s_re));
            sum_im = cau_pkg::SUM_W'($signed(s1_ff.s_im));
         end
      endcase
      neg_re        = -sum_re;
      neg_im        = -sum_im;
      s2_in.op      = s1_ff.op;
      s2_in.neg_re  = sum_re[cau_pkg::SUM_W-1];
      s2_in.neg_im  = sum_im[cau_pkg::SUM_W-1];
      s2_in.mag_re  = sum_re[cau_pkg::SUM_W-1] ? neg_re[cau_pkg::PROD_W-1:0]
                                                : sum_re[cau_pkg::PROD_W-1:0];
      s2_in.mag_im  = sum_im[cau_pkg::SUM_W-1] ? neg_im[cau_pkg::PROD_W-1:0]
                                                : sum_im[cau_pkg::PROD_W-1:0];
      s2_in.den     = s1_ff.p_br2 + s1_ff.p_bi2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= in_valid;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff <= in_data;
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_ff;

endmodule

/* src/cau_div_setup.sv */
// Divider setup stage: overflow test, zero-divisor test and non-divide results.
module cau_div_setup (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  cau_pkg::mag_type  in_data,
   output logic              out_valid,
   output cau_pkg::div_type  out_data
);

   logic              valid_ff;
   cau_pkg::div_type  div_ff, div_in;
   cau_pkg::clamp_type c_re, c_im;
   logic [cau_pkg::SUM_W-1:0] m_re, m_im;
   logic [cau_pkg::REM_W-1:0] lim;

   always_comb begin
      if (in_data.op == cau_pkg::OP_MUL) begin
         m_re = cau_pkg::SUM_W'(in_data.mag_re >> cau_pkg::FRAC_BITS);
         m_im = cau_pkg::SUM_W'(in_data.mag_im >> cau_pkg::FRAC_BITS);
      end else begin
         m_re = cau_pkg::SUM_W'(in_data.mag_re);
         m_im = cau_pkg::SUM_W'(in_data.mag_im);
      end
      c_re = cau_pkg::clamp32(in_data.neg_re, m_re);
      c_im = cau_pkg::clamp32(in_data.neg_im, m_im);
      lim  = cau_pkg::REM_W'(in_data.den) << cau_pkg::QUOT_W;

      div_in.op     = in_data.op;
      div_in.dz     = (in_data.den == '0);
      div_in.neg_re = in_data.neg_re;
      div_in.neg_im = in_data.neg_im;
      div_in.rem_re = cau_pkg::REM_W'(in_data.mag_re) << cau_pkg::FRAC_BITS;
      div_in.rem_im = cau_pkg::REM_W'(in_data.mag_im) << cau_pkg::FRAC_BITS;
      div_in.big_re = (div_in.rem_re >= lim);
      div_in.big_im = (div_in.rem_im >= lim);
      div_in.den    = in_data.den;
      div_in.q_re   = '0;
      div_in.q_im   = '0;
      div_in.res_re = c_re.value;
      div_in.res_im = c_im.value;
      div_in.sat    = c_re.sat | c_im.sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff <= div_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = div_ff;

endmodule

/* src/cau_div_step.sv */
// One restoring-division stage: one quotient bit for each of the two parts.
module cau_div_step (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic [cau_pkg::STEP_W-1:0] step,
   input  logic                       in_valid,
   input  cau_pkg::div_type           in_data,
   output logic                       out_valid,
   output cau_pkg::div_type           out_data
);

   logic              valid_ff;
   cau_pkg::div_type  div_ff, div_in;
   logic [cau_pkg::REM_W-1:0] sh;
   logic              bit_re, bit_im;

   always_comb begin
      sh            = cau_pkg::REM_W'(in_data.den) << step;
      bit_re        = (in_data.rem_re >= sh);
      bit_im        = (in_data.rem_im >= sh);
      div_in        = in_data;
      div_in.rem_re = bit_re ? in_data.rem_re - sh : in_data.rem_re;
      div_in.rem_im = bit_im ? in_data.rem_im - sh : in_data.rem_im;
      div_in.q_re   = {in_data.q_re[cau_pkg::QUOT_W-2:0], bit_re};
      div_in.q_im   = {in_data.q_im[cau_pkg::QUOT_W-2:0], bit_im};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff <= div_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = div_ff;

endmodule

/* src/complex_arith_unit_core.sv */
// Top level of the complex arithmetic unit: pipeline, result stage and skid buffer.
//
// Requests enter on req_* (tuser = operation, tdata = a_re, a_im, b_re, b_im) and
// results leave on rsp_* (tuser = status, tdata = res_re, res_im), all Q16.16.
// Add, subtract, multiply and divide share one pipeline of 37 register stages:
// an input stage, a multiplier stage, a sum stage, a divider setup stage,
// 32 restoring-division stages (one quotient bit each) and a result stage.
// Every request takes the same path through all stages, whatever its operation,
// and one request can be accepted in every cycle while req_tready is high.
// Results saturate to the 32-bit range with status 2; a divide by a zero
// operand gives zero parts with status 1.
// Reset clears all valid bits; the pipeline is empty after it.
// When the receiver holds rsp_tready low, the waiting result moves into a
// one-entry skid buffer and req_tready drops in the next cycle, freezing the
// whole pipeline; no request is lost or repeated. req_tready returns once the
// buffered result is taken.
module complex_arith_unit_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,   // req_type
   input  logic [127:0] req_tdata,   // a_re, a_im, b_re, b_im
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [1:0]   rsp_tuser,   // status
   output logic [63:0]  rsp_tdata    // res_re, res_im
);

   logic                  en;
   logic                  front_valid, setup_valid;
   cau_pkg::operand_type  req;
   cau_pkg::mag_type      front_data;
   cau_pkg::div_type      setup_data;
   logic                  step_valid [cau_pkg::QUOT_W+1];
   cau_pkg::div_type      step_data  [cau_pkg::QUOT_W+1];
   cau_pkg::div_type      last;
   cau_pkg::clamp_type    c_re, c_im;
   cau_pkg::result_type   res_in, res_ff, skid_ff, shown;
   logic                  res_valid_ff, skid_valid_ff, skid_valid_in;

   assign en         = ~skid_valid_ff;
   assign req_tready = en;

   always_comb begin
      req.op   = req_tuser;
      req.a_re = req_tdata[31:0];
      req.a_im = req_tdata[63:32];
      req.b_re = req_tdata[95:64];
      req.b_im = req_tdata[127:96];
   end

   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_data   (req),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   cau_div_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (setup_valid),
      .out_data  (setup_data)
   );

   assign step_valid[0] = setup_valid;
   assign step_data[0]  = setup_data;

   for (genvar g = 0; g < cau_pkg::QUOT_W; g++) begin : g_step
      cau_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .step      (cau_pkg::STEP_W'(cau_pkg::QUOT_W - 1 - g)),
         .in_valid  (step_valid[g]),
         .in_data   (step_data[g]),
         .out_valid (step_valid[g+1]),
         .out_data  (step_data[g+1])
      );
   end

   assign last = step_data[cau_pkg::QUOT_W];

   always_comb begin
      c_re = cau_pkg::clamp32(last.neg_re,
                              last.big_re ? cau_pkg::BIG_MAG : cau_pkg::SUM_W'(last.q_re));
      c_im = cau_pkg::clamp32(last.neg_im,
                              last.big_im ? cau_pkg::BIG_MAG : cau_pkg::SUM_W'(last.q_im));
      if (last.op != cau_pkg::OP_DIV) begin
         res_in.res_re = last.res_re;
         res_in.res_im = last.res_im;
         res_in.status = last.sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end else if (last.dz) begin
         res_in.res_re = '0;
         res_in.res_im = '0;
         res_in.status = cau_pkg::ST_DIVZERO;
      end else begin
         res_in.res_re = c_re.value;
         res_in.res_im = c_im.value;
         res_in.status = (c_re.sat | c_im.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
   end

   always_comb begin
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff && rsp_tready) begin
         skid_valid_in = 1'b0;
      end else if (en && res_valid_ff && !rsp_tready) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
         if (en) begin
            res_valid_ff <= step_valid[cau_pkg::QUOT_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
         if (res_valid_ff && !rsp_tready) begin
            skid_ff <= res_ff;
         end
      end
   end

   assign shown      = skid_valid_ff ? skid_ff : res_ff;
   assign rsp_tvalid = skid_valid_ff | res_valid_ff;
   assign rsp_tuser  = shown.status;
   assign rsp_tdata  = {shown.res_im, shown.res_re};

endmodule
